// ----- src/rrqs_pkg.sv -----
// Shared codes, widths and reset values for the round-robin quantum scheduler.
package rrqs_pkg;

   localparam int ACTION_W   = 2;
   localparam int ID_W       = 4;
   localparam int STATUS_W   = 2;
   localparam int QUANTUM_W  = 16;

   localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_CREATE  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_EXIT    = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_SET_PRI = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_SLOT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_HALTED  = 2'd2;

   localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd100;

   // slots are searched for a free entry in groups of this many
   localparam int GROUP_W = 16;

endpackage

// ----- src/round_robin_quantum_scheduler.sv -----
// Round-robin time-slice thread scheduler: top level.
//
// One request is taken per clock unless a waiting response is stalled; its response is
// presented in the output register the cycle after the transfer, and a new request is
// taken in the same cycle that a waiting response transfers, so the sustained rate is one
// item per cycle while rsp_ready is held, set by the single read-modify-write of the ready
// FIFO memory and the priority memory per item. Both memories have registered reads; the
// FIFO head is prefetched every cycle and the priority of the next running slot is read at
// the transfer, with write bypass where the same entry is written in that cycle. No clearing
// pass is needed after reset. The quantum register is sampled at each counter reload.
module round_robin_quantum_scheduler #(
   parameter int MAX_THREADS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [rrqs_pkg::QUANTUM_W-1:0]   csr_wr_data,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [rrqs_pkg::ACTION_W-1:0]    req_action,
   input  logic                             req_priority_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [rrqs_pkg::ID_W-1:0]        rsp_running_id,
   output logic                             rsp_switched,
   output logic [rrqs_pkg::ID_W-1:0]        rsp_new_slot,
   output logic [rrqs_pkg::STATUS_W-1:0]    rsp_status,
   output logic                             rsp_running_priority
);

   localparam int SW  = $clog2(MAX_THREADS);
   localparam int CW  = $clog2(MAX_THREADS + 1);
   localparam int GW  = rrqs_pkg::GROUP_W;
   localparam int NG  = (MAX_THREADS + GW - 1) / GW;
   localparam int GSW = (NG > 1) ? $clog2(NG) : 1;
   localparam int IW  = rrqs_pkg::ID_W;

   // control state
   logic [MAX_THREADS-1:0]          busy_ff, busy_in;
   logic [SW-1:0]                   head_ff, head_in;
   logic [SW-1:0]                   tail_ff, tail_in;
   logic [CW-1:0]                   count_ff, count_in;
   logic [SW-1:0]                   current_ff, current_in;
   logic [rrqs_pkg::QUANTUM_W-1:0]  ticks_ff, ticks_in;
   logic [rrqs_pkg::QUANTUM_W-1:0]  quantum_ff;
   logic                            halted_ff, halted_in;
   logic                            p0_written_ff;
   logic                            rsp_valid_ff;

   // memories and their read registers
   logic [SW-1:0]  fifo_mem [MAX_THREADS];
   logic           prio_mem [MAX_THREADS];
   logic [SW-1:0]  head_q_ff;
   logic           prio_q_ff;
   logic           prio_unset_ff;

   // response register
   logic [IW-1:0]                  rsp_id_ff;
   logic                           rsp_switched_ff;
   logic [IW-1:0]                  rsp_new_slot_ff;
   logic [rrqs_pkg::STATUS_W-1:0]  rsp_status_ff;

   logic                           accept;
   logic                           pop;
   logic                           push_en;
   logic                           push_ok;
   logic [SW-1:0]                  push_data;
   logic [CW-1:0]                  count_mid;
   logic                           prio_we;
   logic [SW-1:0]                  prio_wa;
   logic                           prio_wd;
   logic                           switched;
   logic [SW-1:0]                  new_slot;
   logic [rrqs_pkg::STATUS_W-1:0]  status;

   // lowest free slot search
   logic [NG*GW-1:0]               busy_pad;
   logic [NG-1:0]                  group_free;
   logic [GSW-1:0]                 group_sel;
   logic [GW-1:0]                  group_word;
   logic [3:0]                     bit_sel;
   logic [GSW+3:0]                 free_full;
   logic [SW-1:0]                  free_slot;
   logic                           any_free;

   logic [SW+IW-1:0]               id_wide;
   logic [SW+IW-1:0]               new_wide;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      busy_pad = '1;
      busy_pad[MAX_THREADS-1:0] = busy_ff;
      for (int g = 0; g < NG; g++) begin
         group_free[g] = ~&busy_pad[g*GW +: GW];
      end
      group_sel = '0;
      for (int g = NG - 1; g >= 0; g--) begin
         if (group_free[g]) begin
            group_sel = GSW'(g);
         end
      end
      group_word = busy_pad[group_sel*GW +: GW];
      bit_sel = '0;
      for (int b = GW - 1; b >= 0; b--) begin
         if (!group_word[b]) begin
            bit_sel = 4'(b);
         end
      end
      free_full = {group_sel, bit_sel};
      free_slot = free_full[SW-1:0];
      any_free  = |group_free;
   end

   function automatic logic [SW-1:0] next_index(input logic [SW-1:0] i);
      next_index = (i == SW'(MAX_THREADS - 1)) ? '0 : i + 1'b1;
   endfunction

   always_comb begin
      busy_in    = busy_ff;
      current_in = current_ff;
      ticks_in   = ticks_ff;
      halted_in  = halted_ff;
      pop        = 1'b0;
      push_en    = 1'b0;
      push_data  = current_ff;
      prio_we    = 1'b0;
      prio_wa    = current_ff;
      prio_wd    = req_priority_value;
      switched   = 1'b0;
      new_slot   = '0;
      status     = rrqs_pkg::ST_OK;

      if (accept && !halted_ff) begin
         case (req_action)
            rrqs_pkg::ACT_TICK: begin
               if (ticks_ff <= rrqs_pkg::QUANTUM_W'(1)) begin
                  ticks_in = quantum_ff;
                  if (count_ff != '0) begin
                     pop        = 1'b1;
                     push_en    = 1'b1;
                     push_data  = current_ff;
                     current_in = head_q_ff;
                     switched   = 1'b1;
                  end
               end else begin
                  ticks_in = ticks_ff - 1'b1;
               end
            end
            rrqs_pkg::ACT_CREATE: begin
               if (any_free) begin
                  busy_in[free_slot] = 1'b1;
                  prio_we   = 1'b1;
                  prio_wa   = free_slot;
                  push_en   = 1'b1;
                  push_data = free_slot;
                  new_slot  = free_slot;
               end else begin
                  status = rrqs_pkg::ST_NO_SLOT;
               end
            end
            rrqs_pkg::ACT_EXIT: begin
               busy_in[current_ff] = 1'b0;
               ticks_in = quantum_ff;
               if (count_ff != '0) begin
                  pop        = 1'b1;
                  current_in = head_q_ff;
                  switched   = 1'b1;
               end else begin
                  halted_in = 1'b1;
               end
            end
            rrqs_pkg::ACT_SET_PRI: begin
               prio_we = 1'b1;
               prio_wa = current_ff;
            end
            default: begin
               status = rrqs_pkg::ST_OK;
            end
         endcase
      end

      // pop happens before push, so a full check uses the count after the pop
      count_mid = pop ? count_ff - 1'b1 : count_ff;
      push_ok   = push_en && (count_mid != CW'(MAX_THREADS));
      head_in   = pop ? next_index(head_ff) : head_ff;
      tail_in   = push_ok ? next_index(tail_ff) : tail_ff;
      count_in  = push_ok ? count_mid + 1'b1 : count_mid;

      id_wide  = {{IW{1'b0}}, current_in};
      new_wide = {{IW{1'b0}}, new_slot};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= MAX_THREADS'(1);
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         current_ff    <= '0;
         ticks_ff      <= rrqs_pkg::QUANTUM_RESET;
         quantum_ff    <= rrqs_pkg::QUANTUM_RESET;
         halted_ff     <= 1'b0;
         p0_written_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         count_ff   <= count_in;
         current_ff <= current_in;
         ticks_ff   <= ticks_in;
         halted_ff  <= halted_in;
         if (csr_wr_en) begin
            quantum_ff <= csr_wr_data;
         end
         if (prio_we && prio_wa == '0) begin
            p0_written_ff <= 1'b1;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ready FIFO: head entry prefetched every cycle, bypassed on a same-entry write
   always_ff @(posedge clock) begin
      if (push_ok) begin
         fifo_mem[tail_ff] <= push_data;
      end
      if (push_ok && tail_ff == head_in) begin
         head_q_ff <= push_data;
      end else begin
         head_q_ff <= fifo_mem[head_in];
      end
   end

   // priority store: read of the next running slot at each transfer
   always_ff @(posedge clock) begin
      if (prio_we) begin
         prio_mem[prio_wa] <= prio_wd;
      end
      if (accept) begin
         if (prio_we && prio_wa == current_in) begin
            prio_q_ff <= prio_wd;
         end else begin
            prio_q_ff <= prio_mem[current_in];
         end
         // slot 0 reads as low priority until its entry is first written
         prio_unset_ff <= (current_in == '0) && !p0_written_ff &&
                          !(prio_we && prio_wa == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (halted_in) begin
            rsp_id_ff       <= '0;
            rsp_switched_ff <= 1'b0;
            rsp_new_slot_ff <= '0;
            rsp_status_ff   <= rrqs_pkg::ST_HALTED;
         end else begin
            rsp_id_ff       <= id_wide[IW-1:0];
            rsp_switched_ff <= switched;
            rsp_new_slot_ff <= new_wide[IW-1:0];
            rsp_status_ff   <= status;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_running_id       = rsp_id_ff;
   assign rsp_switched         = rsp_switched_ff;
   assign rsp_new_slot         = rsp_new_slot_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_running_priority = prio_q_ff && !prio_unset_ff &&
                                 (rsp_status_ff != rrqs_pkg::ST_HALTED);

endmodule

// ----- src/rrqs_checker.sv -----
// Port-level checks for the round-robin quantum scheduler, with its bind.
module rrqs_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [rrqs_pkg::ID_W-1:0]        rsp_running_id,
   input logic                             rsp_switched,
   input logic [rrqs_pkg::ID_W-1:0]        rsp_new_slot,
   input logic [rrqs_pkg::STATUS_W-1:0]    rsp_status,
   input logic                             rsp_running_priority
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_running_id) &&
      $stable(rsp_switched) && $stable(rsp_new_slot) && $stable(rsp_status) &&
      $stable(rsp_running_priority))
      else $error("response changed while stalled");

   a_halt_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == rrqs_pkg::ST_HALTED |->
      rsp_running_id == '0 && !rsp_switched && rsp_new_slot == '0 &&
      !rsp_running_priority)
      else $error("halted response carries nonzero fields");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_status == rrqs_pkg::ST_HALTED |=>
      !rsp_valid || rsp_status == rrqs_pkg::ST_HALTED)
      else $error("scheduler left halt without reset");

   a_no_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == rrqs_pkg::ST_NO_SLOT |->
      rsp_new_slot == '0 && !rsp_switched)
      else $error("failed create reported a slot or a switch");

   a_switch_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_switched |->
      rsp_status == rrqs_pkg::ST_OK && rsp_new_slot == '0)
      else $error("switch reported with a create result");

endmodule

bind round_robin_quantum_scheduler rrqs_checker u_rrqs_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_running_id       (rsp_running_id),
   .rsp_switched         (rsp_switched),
   .rsp_new_slot         (rsp_new_slot),
   .rsp_status           (rsp_status),
   .rsp_running_priority (rsp_running_priority)
);

// ----- tb/sched_check_pkg.sv -----
// Scoreboard class for the round-robin quantum scheduler: scheduler state copy and checks.
package sched_check_pkg;
   import rrqs_pkg::*;

   localparam int N_SLOTS = 16;

   typedef struct packed {
      logic [ID_W-1:0]     running_id;
      logic                switched;
      logic [ID_W-1:0]     new_slot;
      logic [STATUS_W-1:0] status;
      logic                running_priority;
   } sched_outcome_type;

   class sched_tracker;
      logic [QUANTUM_W-1:0] quantum;
      logic                 slot_used [N_SLOTS];
      logic                 slot_prio [N_SLOTS];
      logic [ID_W-1:0]      ready_ring [N_SLOTS];
      int                   ring_head;
      int                   ring_tail;
      int                   ring_count;
      logic [ID_W-1:0]      cur_slot;
      logic [QUANTUM_W-1:0] ticks_left;
      bit                   stopped;
      sched_outcome_type    pending_outcomes [$];
      int                   n_errors;
      int                   n_requests;
      int                   n_responses;
      int                   n_switches;
      int                   n_no_slot;
      int                   n_idle_expiry;
      int                   n_halted;

      function new();
         for (int i = 0; i < N_SLOTS; i++) begin
            slot_used[i] = 1'b0;
            slot_prio[i] = 1'b0;
            ready_ring[i] = '0;
         end
         slot_used[0] = 1'b1;
         quantum = QUANTUM_RESET;
         ticks_left = QUANTUM_RESET;
         ring_head = 0;
         ring_tail = 0;
         ring_count = 0;
         cur_slot = '0;
         stopped = 1'b0;
         n_errors = 0;
         n_requests = 0;
         n_responses = 0;
         n_switches = 0;
         n_no_slot = 0;
         n_idle_expiry = 0;
         n_halted = 0;
      endfunction

      function void set_quantum(logic [QUANTUM_W-1:0] q);
         quantum = q;
      endfunction

      function int live_threads();
         int n;
         n = 0;
         for (int i = 0; i < N_SLOTS; i++)
            if (slot_used[i]) n++;
         return n;
      endfunction

      function void ring_push(logic [ID_W-1:0] slot);
         if (ring_count >= N_SLOTS) return;
         ready_ring[ring_tail] = slot;
         ring_tail = (ring_tail + 1) % N_SLOTS;
         ring_count++;
      endfunction

      function logic [ID_W-1:0] ring_pop();
         logic [ID_W-1:0] s;
         s = ready_ring[ring_head];
         ring_head = (ring_head + 1) % N_SLOTS;
         ring_count--;
         return s;
      endfunction

      // Advances the scheduler copy by one accepted request and queues the response it implies.
      function void note_request(logic [ACTION_W-1:0] act, logic pri);
         sched_outcome_type r;
         logic [ID_W-1:0] nxt;
         int free_slot;
         r = '0;
         n_requests++;
         if (!stopped) begin
            case (act)
               ACT_TICK: begin
                  if (ticks_left <= 1) begin
                     ticks_left = quantum;
                     if (ring_count > 0) begin
                        nxt = ring_pop();
                        ring_push(cur_slot);
                        cur_slot = nxt;
                        r.switched = 1'b1;
                     end else begin
                        n_idle_expiry++;
                     end
                  end else begin
                     ticks_left = ticks_left - 1'b1;
                  end
               end
               ACT_CREATE: begin
                  free_slot = -1;
                  for (int i = N_SLOTS - 1; i >= 0; i--)
                     if (!slot_used[i]) free_slot = i;
                  if (free_slot < 0) begin
                     r.status = ST_NO_SLOT;
                     n_no_slot++;
                  end else begin
                     slot_used[free_slot] = 1'b1;
                     slot_prio[free_slot] = pri;
                     ring_push(free_slot[ID_W-1:0]);
                     r.new_slot = free_slot[ID_W-1:0];
                  end
               end
               ACT_EXIT: begin
                  slot_used[cur_slot] = 1'b0;
                  ticks_left = quantum;
                  if (ring_count > 0) begin
                     cur_slot = ring_pop();
                     r.switched = 1'b1;
                  end else begin
                     stopped = 1'b1;
                  end
               end
               default: slot_prio[cur_slot] = pri;
            endcase
         end
         if (stopped) begin
            r = '0;
            r.status = ST_HALTED;
            n_halted++;
         end else begin
            r.running_id = cur_slot;
            r.running_priority = slot_prio[cur_slot];
            if (r.switched) n_switches++;
         end
         pending_outcomes.push_back(r);
      endfunction

      task report(string what);
         n_errors++;
         $display("MISMATCH %0d: %s", n_errors, what);
      endtask

      task check_response(sched_outcome_type got);
         sched_outcome_type want;
         n_responses++;
         if (pending_outcomes.size() == 0) begin
            report($sformatf("response %0d arrived with nothing expected", n_responses));
            return;
         end
         want = pending_outcomes.pop_front();
         if (got.running_id !== want.running_id)
            report($sformatf("response %0d running_id %0d, expected %0d",
                             n_responses, got.running_id, want.running_id));
         if (got.switched !== want.switched)
            report($sformatf("response %0d switched %0b, expected %0b",
                             n_responses, got.switched, want.switched));
         if (got.new_slot !== want.new_slot)
            report($sformatf("response %0d new_slot %0d, expected %0d",
                             n_responses, got.new_slot, want.new_slot));
         if (got.status !== want.status)
            report($sformatf("response %0d status %0d, expected %0d",
                             n_responses, got.status, want.status));
         if (got.running_priority !== want.running_priority)
            report($sformatf("response %0d running_priority %0b, expected %0b",
                             n_responses, got.running_priority, want.running_priority));
      endtask
   endclass

endpackage

// ----- tb/tb.sv -----
// Testbench top for the round-robin quantum scheduler: stimulus, response side, run control.
module tb;
   import rrqs_pkg::*;
   import sched_check_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [QUANTUM_W-1:0] csr_wr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [ACTION_W-1:0]  req_action = ACT_TICK;
   logic                 req_priority_value = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [ID_W-1:0]      rsp_running_id;
   logic                 rsp_switched;
   logic [ID_W-1:0]      rsp_new_slot;
   logic [STATUS_W-1:0]  rsp_status;
   logic                 rsp_running_priority;

   sched_tracker sb;
   bit calm = 1'b0;
   int hold_requests = 0;
   int holds_done = 0;
   int hold_left = 0;

   always #5 clock = ~clock;

   round_robin_quantum_scheduler i_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_action           (req_action),
      .req_priority_value   (req_priority_value),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_running_id       (rsp_running_id),
      .rsp_switched         (rsp_switched),
      .rsp_new_slot         (rsp_new_slot),
      .rsp_status           (rsp_status),
      .rsp_running_priority (rsp_running_priority)
   );

   // response side: check each transfer, then choose next ready
   always @(posedge clock) begin : rsp_side
      sched_outcome_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.running_id = rsp_running_id;
         got.switched = rsp_switched;
         got.new_slot = rsp_new_slot;
         got.status = rsp_status;
         got.running_priority = rsp_running_priority;
         sb.check_response(got);
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (holds_done < hold_requests) begin
         // long back-pressure so the block fills and stalls its request side
         holds_done = holds_done + 1;
         hold_left = 80;
         rsp_ready <= 1'b0;
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= 17);
      end
   end

   task automatic send_req(input logic [ACTION_W-1:0] act, input logic pri);
      req_valid <= 1'b1;
      req_action <= act;
      req_priority_value <= pri;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(act, pri);
   endtask

   task automatic pause_req(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // stop offering and wait until every expected response has been taken
   task automatic drain();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_outcomes.size() > 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (3) @(posedge clock);
   endtask

   task automatic write_quantum(input logic [QUANTUM_W-1:0] q);
      csr_wr_en <= 1'b1;
      csr_wr_data <= q;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_quantum(q);
   endtask

   task automatic directed();
      send_req(ACT_SET_PRI, 1'b1);
      send_req(ACT_TICK, 1'b0);
      send_req(ACT_CREATE, 1'b0);
      send_req(ACT_CREATE, 1'b1);
      drain();
      write_quantum('0);
      send_req(ACT_EXIT, 1'b1);    // reload with a zero quantum
      send_req(ACT_TICK, 1'b1);    // counter at zero expires at once
      send_req(ACT_TICK, 1'b0);
      send_req(ACT_SET_PRI, 1'b0);
      drain();
      write_quantum(16'd1);
      for (int i = 0; i < 14; i++) send_req(ACT_CREATE, i[0]);   // every slot taken
      send_req(ACT_CREATE, 1'b1);  // no free slot
      send_req(ACT_TICK, 1'b1);    // expiry with fifteen threads in the ready queue
      send_req(ACT_EXIT, 1'b0);
   endtask

   task automatic run_phase(input int n, input int create_pct, input int exit_pct,
                            input int pri_pct, input bit quiet, input bit squeeze);
      int r;
      logic [ACTION_W-1:0] act;
      calm = quiet;
      for (int k = 0; k < n; k++) begin
         if (squeeze && k == n / 4) hold_requests = hold_requests + 1;
         if (!quiet && $urandom_range(0, 99) < 20) pause_req(1);
         r = $urandom_range(0, 99);
         if (r < create_pct) act = ACT_CREATE;
         else if (r < create_pct + exit_pct) act = ACT_EXIT;
         else if (r < create_pct + exit_pct + pri_pct) act = ACT_SET_PRI;
         else act = ACT_TICK;
         if ($urandom_range(0, 19) == 0) act = ACTION_W'($urandom_range(0, 3));
         // the last thread only leaves at the very end of the run
         if (act == ACT_EXIT && sb.live_threads() < 2) act = ACT_CREATE;
         send_req(act, 1'($urandom_range(0, 1)));
      end
      calm = 1'b0;
   endtask

   task automatic wind_down();
      drain();
      write_quantum(16'd2);
      while (sb.live_threads() > 1)
         send_req($urandom_range(0, 1) ? ACT_EXIT : ACT_TICK, 1'($urandom_range(0, 1)));
      repeat (6) send_req(ACT_TICK, 1'b0);   // lone thread, nothing queued
      send_req(ACT_SET_PRI, 1'b1);
      send_req(ACT_EXIT, 1'b0);              // last thread leaves, block halts
      send_req(ACT_TICK, 1'b1);
      send_req(ACT_CREATE, 1'b0);
      send_req(ACT_EXIT, 1'b1);
      send_req(ACT_SET_PRI, 1'b0);
   endtask

   initial begin : stimulus
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      directed();
      drain();
      write_quantum(16'd3);
      run_phase(220, 25, 10, 15, 1'b0, 1'b0);
      drain();
      write_quantum(16'd1);
      run_phase(220, 20, 15, 15, 1'b0, 1'b1);
      drain();
      write_quantum(16'hFFFF);
      run_phase(160, 20, 20, 10, 1'b0, 1'b0);
      drain();
      write_quantum(QUANTUM_W'($urandom_range(2, 6)));
      run_phase(200, 15, 25, 15, 1'b1, 1'b0);
      drain();
      write_quantum('0);
      run_phase(180, 25, 15, 10, 1'b0, 1'b1);
      drain();
      write_quantum(QUANTUM_W'($urandom_range(0, 65535)));
      run_phase(120, 20, 20, 20, 1'b0, 1'b0);
      drain();
      write_quantum(QUANTUM_W'($urandom_range(1, 4)));
      run_phase(220, 30, 10, 10, 1'b0, 1'b0);
      wind_down();
      drain();
      repeat (5) @(posedge clock);
      while (sb.pending_outcomes.size() > 0) begin
         void'(sb.pending_outcomes.pop_front());
         sb.report("expected response never arrived");
      end
      $display("run: %0d requests, %0d responses, %0d context switches, %0d failed creates",
               sb.n_requests, sb.n_responses, sb.n_switches, sb.n_no_slot);
      $display("run: quantum 0, 1, 2, 3, max and random; %0d idle expiries, %0d halted",
               sb.n_idle_expiry, sb.n_halted);
      if (sb.n_errors == 0) begin
         $display("PASS round_robin_quantum_scheduler");
      end else begin
         $display("FAIL round_robin_quantum_scheduler");
      end
      $finish;
   end

   initial begin : watchdog
      #3000000;
      $display("FAIL round_robin_quantum_scheduler");
      $finish;
   end

endmodule
